[rtl/ongt_pkg.sv]
// Shared constants for the octree node group table: field widths, operation
// and status codes. No dependencies.
`default_nettype none

package ongt_pkg;

    localparam int OP_W     = 3;
    localparam int NODE_W   = 10;
    localparam int SLOT_W   = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    // wide enough for any node index the store can be built with
    localparam int IDX_W    = 17;

    localparam logic [OP_W-1:0] OP_GET_CHILD     = 3'd0;
    localparam logic [OP_W-1:0] OP_PEEK_CHILD    = 3'd1;
    localparam logic [OP_W-1:0] OP_GET_PARENT    = 3'd2;
    localparam logic [OP_W-1:0] OP_PEEK_PARENT   = 3'd3;
    localparam logic [OP_W-1:0] OP_DROP_CHILDREN = 3'd4;
    localparam logic [OP_W-1:0] OP_READ_PAYLOAD  = 3'd5;
    localparam logic [OP_W-1:0] OP_WRITE_PAYLOAD = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_NODE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

endpackage

`default_nettype wire

[rtl/ongt_req_if.sv]
// Request channel of the octree node group table: valid/ready and payload.
// Depends on ongt_pkg.
`default_nettype none

interface ongt_req_if;
    logic                           valid;
    logic                           ready;
    logic [ongt_pkg::OP_W-1:0]      op;
    logic [ongt_pkg::NODE_W-1:0]    node_index;
    logic [ongt_pkg::SLOT_W-1:0]    child_slot;
    logic [ongt_pkg::DATA_W-1:0]    data_in;

    modport source (output valid, op, node_index, child_slot, data_in, input ready);
    modport sink   (input valid, op, node_index, child_slot, data_in, output ready);
endinterface

`default_nettype wire

[rtl/ongt_rsp_if.sv]
// Result channel of the octree node group table: valid/ready and payload.
// Depends on ongt_pkg.
`default_nettype none

interface ongt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [ongt_pkg::NODE_W-1:0]    result_node;
    logic [ongt_pkg::STATUS_W-1:0]  status;
    logic                           has_children;
    logic [ongt_pkg::DATA_W-1:0]    data_out;

    modport source (output valid, result_node, status, has_children, data_out, input ready);
    modport sink   (input valid, result_node, status, has_children, data_out, output ready);
endinterface

`default_nettype wire

[rtl/ongt_row_ram.sv]
// Group row memory: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module ongt_row_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/octree_node_group_table.sv]
// Octree node group table: nodes in groups of eight, one memory row per group.
// Result path: the row read is registered; S_MOD computes the result and loads the output
//   register, or S_ALLOC does after writing a taken group's new row; S_HOLD waits on a busy output.
// Requests wait for S_IDLE, after read and write-back of the single row memory (one write port).
// Reset: a clearing pass zeroes all NODE_COUNT/8 rows (128 by default); requests wait.
// Depends on ongt_pkg, ongt_req_if, ongt_rsp_if and ongt_row_ram.
`default_nettype none

module octree_node_group_table #(
    parameter int NODE_COUNT   = 1024,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ongt_req_if.sink    req,
    ongt_rsp_if.source  rsp
);

    localparam int GROUP_COUNT = NODE_COUNT / 8;
    localparam int USED_NODES  = GROUP_COUNT * 8;
    localparam int NW          = $clog2(USED_NODES);
    localparam int GW          = NW - 3;
    localparam int FGW         = $clog2(GROUP_COUNT + 1);
    localparam int PB          = PAYLOAD_BITS;
    // row layout: child present bits, child groups, parent present, parent node, payloads
    localparam int CG_LO       = 8;
    localparam int PP_BIT      = CG_LO + 8 * GW;
    localparam int PN_LO       = PP_BIT + 1;
    localparam int PL_LO       = PN_LO + NW;
    localparam int ROW_W       = PL_LO + 8 * PB;
    localparam int IDX_W       = ongt_pkg::IDX_W;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_MOD, S_ALLOC, S_HOLD} state_t;

    state_t                         state_reg;
    logic [GW-1:0]                  clr_reg;
    logic [FGW-1:0]                 free_grp_reg;

    logic                           rsp_valid_reg;
    logic [ongt_pkg::NODE_W-1:0]    rsp_node_reg;
    logic [ongt_pkg::STATUS_W-1:0]  rsp_status_reg;
    logic                           rsp_hc_reg;
    logic [ongt_pkg::DATA_W-1:0]    rsp_dout_reg;

    logic [ongt_pkg::NODE_W-1:0]    pend_node_reg;
    logic [ongt_pkg::STATUS_W-1:0]  pend_status_reg;
    logic                           pend_hc_reg;
    logic [ongt_pkg::DATA_W-1:0]    pend_dout_reg;

    logic [ongt_pkg::OP_W-1:0]      op_reg;
    logic [NW-1:0]                  n_reg;
    logic [ongt_pkg::SLOT_W-1:0]    slot_reg;
    logic [PB-1:0]                  din_reg;
    logic                           bad_reg;
    logic [ROW_W-1:0]               h_row_reg;
    logic [GW-1:0]                  h_reg;

    logic                           accept;
    logic                           rsp_free;
    logic                           rsp_load;
    logic [IDX_W-1:0]               idx_wide;
    logic                           req_bad;
    logic [63:0]                    din_wide;

    logic                           wr_en;
    logic [GW-1:0]                  wr_addr;
    logic [ROW_W-1:0]               wr_data;
    logic [ROW_W-1:0]               row_rd;

    logic [2:0]                     off;
    logic [GW-1:0]                  g;
    logic [GW-1:0]                  h;
    logic                           room;
    logic                           same_grp;
    logic                           cp_n;
    logic [GW-1:0]                  cg_n;
    logic                           pp_g;
    logic [NW-1:0]                  pn_g;
    logic [2:0]                     p_off;
    logic [NW-1:0]                  p_node;

    logic [ROW_W-1:0]               g_row_new;
    logic [ROW_W-1:0]               h_row;
    logic                           g_wr;
    logic                           alloc;
    logic [NW-1:0]                  res;
    logic [ongt_pkg::STATUS_W-1:0]  status;
    logic [PB-1:0]                  dout;
    logic                           has_children;
    logic [IDX_W-1:0]               res_wide;
    logic [63:0]                    dout_wide;
    logic [ongt_pkg::NODE_W-1:0]    res_port;
    logic [ongt_pkg::DATA_W-1:0]    dout_port;

    assign accept   = req.valid && req.ready;
    assign rsp_free = !rsp_valid_reg || rsp.ready;
    assign idx_wide = IDX_W'(req.node_index);
    assign req_bad  = (idx_wide >= IDX_W'(USED_NODES)) || (req.op > ongt_pkg::OP_WRITE_PAYLOAD);
    assign din_wide = 64'(req.data_in);

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.result_node  = rsp_node_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.has_children = rsp_hc_reg;
    assign rsp.data_out     = rsp_dout_reg;

    ongt_row_ram #(
        .DEPTH (GROUP_COUNT),
        .WIDTH (ROW_W)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (idx_wide[NW-1:3]),
        .rd_data (row_rd)
    );

    // fields of the addressed node and its group, read in the previous cycle
    assign off      = n_reg[2:0];
    assign g        = n_reg[NW-1:3];
    assign h        = free_grp_reg[GW-1:0];
    assign room     = free_grp_reg < FGW'(GROUP_COUNT);
    assign same_grp = (h == g);
    assign cp_n     = row_rd[off];
    assign cg_n     = row_rd[CG_LO + int'(off) * GW +: GW];
    assign pp_g     = row_rd[PP_BIT];
    assign pn_g     = row_rd[PN_LO +: NW];
    // a new parent hangs the old group at offset 0 for odd groups, 7 for even
    assign p_off    = g[0] ? 3'd0 : 3'd7;
    assign p_node   = {h, p_off};

    always_comb
    begin
        g_row_new = row_rd;
        h_row     = '0;
        g_wr      = 1'b0;
        alloc     = 1'b0;
        res       = n_reg;
        status    = ongt_pkg::ST_OK;
        dout      = '0;
        unique case (op_reg)
            ongt_pkg::OP_GET_CHILD:
            begin
                if (cp_n)
                begin
                    res = {cg_n, slot_reg};
                end
                else if (!room)
                begin
                    status = ongt_pkg::ST_FULL;
                    res    = '0;
                end
                else
                begin
                    alloc = 1'b1;
                    g_wr  = 1'b1;
                    g_row_new[off]                          = 1'b1;
                    g_row_new[CG_LO + int'(off) * GW +: GW] = h;
                    h_row[PP_BIT]                           = 1'b1;
                    h_row[PN_LO +: NW]                      = n_reg;
                    // new group is the node's own group: merge both updates
                    if (same_grp)
                    begin
                        h_row[off]                          = 1'b1;
                        h_row[CG_LO + int'(off) * GW +: GW] = h;
                    end
                    res = {h, slot_reg};
                end
            end
            ongt_pkg::OP_PEEK_CHILD:
            begin
                if (cp_n)
                begin
                    res = {cg_n, slot_reg};
                end
                else
                begin
                    status = ongt_pkg::ST_NO_NODE;
                    res    = '0;
                end
            end
            ongt_pkg::OP_GET_PARENT:
            begin
                if (pp_g)
                begin
                    res = pn_g;
                end
                else if (!room)
                begin
                    status = ongt_pkg::ST_FULL;
                    res    = '0;
                end
                else
                begin
                    alloc = 1'b1;
                    g_wr  = 1'b1;
                    g_row_new[PP_BIT]                         = 1'b1;
                    g_row_new[PN_LO +: NW]                    = p_node;
                    h_row[p_off]                              = 1'b1;
                    h_row[CG_LO + int'(p_off) * GW +: GW]     = g;
                    if (same_grp)
                    begin
                        h_row[PP_BIT]      = 1'b1;
                        h_row[PN_LO +: NW] = p_node;
                    end
                    res = p_node;
                end
            end
            ongt_pkg::OP_PEEK_PARENT:
            begin
                if (pp_g)
                begin
                    res = pn_g;
                end
                else
                begin
                    status = ongt_pkg::ST_NO_NODE;
                    res    = '0;
                end
            end
            ongt_pkg::OP_DROP_CHILDREN:
            begin
                g_wr           = 1'b1;
                g_row_new[off] = 1'b0;
            end
            ongt_pkg::OP_READ_PAYLOAD:
            begin
                dout = row_rd[PL_LO + int'(off) * PB +: PB];
            end
            ongt_pkg::OP_WRITE_PAYLOAD:
            begin
                g_wr = 1'b1;
                g_row_new[PL_LO + int'(off) * PB +: PB] = din_reg;
            end
            default:
            begin
                status = ongt_pkg::ST_NO_NODE;
                res    = '0;
            end
        endcase
        has_children = (alloc && same_grp) ? h_row[off] : g_row_new[off];
        // out-of-range node or unused code: report no node, change nothing
        if (bad_reg)
        begin
            g_wr         = 1'b0;
            alloc        = 1'b0;
            res          = '0;
            status       = ongt_pkg::ST_NO_NODE;
            dout         = '0;
            has_children = 1'b0;
        end
    end

    assign res_wide  = IDX_W'(res);
    assign dout_wide = 64'(dout);
    assign res_port  = res_wide[ongt_pkg::NODE_W-1:0];
    assign dout_port = dout_wide[ongt_pkg::DATA_W-1:0];

    // load the output register whenever a finished result meets a free slot
    assign rsp_load = rsp_free && (((state_reg == S_MOD) && !alloc)
                                   || (state_reg == S_ALLOC) || (state_reg == S_HOLD));

    // memory write port: clearing pass, write-back of the addressed row, new group row
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = g;
        wr_data = g_row_new;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
            end
            S_MOD:
            begin
                wr_en = g_wr;
            end
            S_ALLOC:
            begin
                wr_en   = 1'b1;
                wr_addr = h_reg;
                wr_data = h_row_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            free_grp_reg   <= FGW'(1);
            rsp_valid_reg  <= 1'b0;
            rsp_node_reg   <= '0;
            rsp_status_reg <= ongt_pkg::ST_OK;
            rsp_hc_reg     <= 1'b0;
            rsp_dout_reg   <= '0;
        end
        else
        begin
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + GW'(1);
                    if (clr_reg == GW'(GROUP_COUNT - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_MOD;
                    end
                end
                S_MOD:
                begin
                    if (alloc)
                    begin
                        state_reg <= S_ALLOC;
                    end
                    else if (rsp_free)
                    begin
                        rsp_node_reg   <= res_port;
                        rsp_status_reg <= status;
                        rsp_hc_reg     <= has_children;
                        rsp_dout_reg   <= dout_port;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_HOLD;
                    end
                end
                S_ALLOC:
                begin
                    free_grp_reg <= free_grp_reg + FGW'(1);
                    if (rsp_free)
                    begin
                        rsp_node_reg   <= pend_node_reg;
                        rsp_status_reg <= pend_status_reg;
                        rsp_hc_reg     <= pend_hc_reg;
                        rsp_dout_reg   <= pend_dout_reg;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_HOLD;
                    end
                end
                S_HOLD:
                begin
                    if (rsp_free)
                    begin
                        rsp_node_reg   <= pend_node_reg;
                        rsp_status_reg <= pend_status_reg;
                        rsp_hc_reg     <= pend_hc_reg;
                        rsp_dout_reg   <= pend_dout_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // request latch, new group row, and results held for S_ALLOC or while the output register is busy
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.op;
            n_reg    <= idx_wide[NW-1:0];
            slot_reg <= req.child_slot;
            din_reg  <= din_wide[PB-1:0];
            bad_reg  <= req_bad;
        end
        if (state_reg == S_MOD)
        begin
            h_row_reg       <= h_row;
            h_reg           <= h;
            pend_node_reg   <= res_port;
            pend_status_reg <= status;
            pend_hc_reg     <= has_children;
            pend_dout_reg   <= dout_port;
        end
    end

    // a request is read only when no write-back is under way
    assert property (@(posedge clk) disable iff (!rst_n) accept |-> !wr_en)
        else $error("row read collides with a write");

    assert property (@(posedge clk) disable iff (!rst_n)
        (free_grp_reg >= FGW'(1)) && (free_grp_reg <= FGW'(GROUP_COUNT)))
        else $error("free group pointer out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_ALLOC) |=> (free_grp_reg == $past(free_grp_reg)))
        else $error("free pointer moved without allocation");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALLOC) |-> ($past(state_reg) == S_MOD))
        else $error("allocation not preceded by a row read");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_status_reg != ongt_pkg::ST_OK))
            |-> ((rsp_node_reg == '0) && (rsp_dout_reg == '0)))
        else $error("failed request carries data");

endmodule

`default_nettype wire
